>>> rtl/core/swrl_pkg.sv
package swrl_pkg;

	// Width of the length fields on the result channel
	localparam int LEN_W = 13;

	// Width of the range limit register
	localparam int LIMIT_W = 31;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAX_RD,
		ST_MAX_CMP,
		ST_MIN_RD,
		ST_MIN_CMP,
		ST_RNG_RD,
		ST_RNG_CMP,
		ST_DONE
	} state_t;

endpackage

>>> rtl/core/sliding_window_range_limit.sv
// Sliding-window range limiter. For each signed sample the block returns the length of the
// longest window ending at that sample whose maximum minus minimum stays within range_limit,
// and the longest such window so far in the sequence. start_req clears the sequence first;
// samples beyond MAX_SEQ_LEN in one sequence are flagged with overflow and change nothing.
// The running maximum and minimum live in two monotonic deques, each held in a RAM with one
// write and one registered read per cycle, and one shared signed subtractor serves every
// value compare. For each entry popped from a deque tail and each step of the left edge, a
// sample passes through a read state and a compare state; it also waits in its final state
// while the previous result is held by out_stall. Every sample is pushed and popped at most
// once per deque, and over a sequence the left edge steps at most once per sample. An
// overflowed sample goes straight from idle to the done state. range_limit may be rewritten
// only while the block is idle.
module sliding_window_range_limit #(
	parameter int MAX_SEQ_LEN = 4096,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [swrl_pkg::LIMIT_W-1:0]        cfg_wdata,
	// sample channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic                                start_req,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [swrl_pkg::LEN_W-1:0]          best_length,
	output logic [swrl_pkg::LEN_W-1:0]          window_length,
	output logic                                overflow
);

	localparam int AW    = $clog2(MAX_SEQ_LEN);
	localparam int CW    = $clog2(MAX_SEQ_LEN + 1);
	localparam int EW    = SAMPLE_BITS + AW;
	localparam int CMP_W = (SAMPLE_BITS + 1 > swrl_pkg::LIMIT_W + 1) ?
		SAMPLE_BITS + 1 : swrl_pkg::LIMIT_W + 1;
	localparam int LEN_W = swrl_pkg::LEN_W;

	swrl_pkg::state_t state_q, state_d;

	logic [swrl_pkg::LIMIT_W-1:0] limit_q;
	logic signed [SAMPLE_BITS-1:0] v_q;
	logic                          ovf_q;

	logic [AW-1:0] max_head_q, min_head_q, left_q;
	logic [CW-1:0] max_tail_q, min_tail_q, pos_q, best_q;

	logic             out_valid_q;
	logic [LEN_W-1:0] best_out_q, win_out_q;
	logic             ovf_out_q;

	// deque storage: {value, position}
	logic [EW-1:0] max_mem [MAX_SEQ_LEN];
	logic [EW-1:0] min_mem [MAX_SEQ_LEN];
	logic [EW-1:0] max_rdata_q, min_rdata_q;

	logic          max_we, min_we;
	logic [AW-1:0] max_raddr, min_raddr;
	logic [EW-1:0] push_entry;

	logic signed [SAMPLE_BITS-1:0] max_val, min_val, op_a, op_b;
	logic [AW-1:0]                 max_pos, min_pos, i_idx;
	logic signed [CMP_W-1:0]       diff, limit_ext;

	logic in_acc, ovf_in, max_nonempty, min_nonempty, diff_ge0, shrink, left_lt_i;
	logic out_load;
	logic [CW-1:0]          win_c, best_c;
	logic [CW+LEN_W-1:0]    win_ext, best_ext;

	// Unpack read data and the current sample position
	assign max_val    = $signed(max_rdata_q[EW-1:AW]);
	assign min_val    = $signed(min_rdata_q[EW-1:AW]);
	assign max_pos    = max_rdata_q[AW-1:0];
	assign min_pos    = min_rdata_q[AW-1:0];
	assign i_idx      = pos_q[AW-1:0];
	assign push_entry = {v_q, i_idx};

	assign in_acc       = in_valid && !in_stall;
	assign ovf_in       = !start_req && (pos_q >= CW'(MAX_SEQ_LEN));
	assign max_nonempty = max_tail_q > CW'(max_head_q);
	assign min_nonempty = min_tail_q > CW'(min_head_q);
	assign left_lt_i    = left_q < i_idx;

	// Shared subtractor, at least one bit wider than a sample
	assign diff      = CMP_W'(op_a) - CMP_W'(op_b);
	assign limit_ext = $signed(CMP_W'(limit_q));
	assign diff_ge0  = !diff[CMP_W-1];
	assign shrink    = diff > limit_ext;

	// Window length and running best
	assign win_c  = CW'(i_idx) - CW'(left_q) + CW'(1);
	assign best_c = (win_c > best_q) ? win_c : best_q;
	assign win_ext  = {{LEN_W{1'b0}}, win_c};
	assign best_ext = {{LEN_W{1'b0}}, (ovf_q ? best_q : best_c)};

	assign out_load = (state_q == swrl_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swrl_pkg::ST_IDLE: begin
				if (in_valid) state_d = ovf_in ? swrl_pkg::ST_DONE : swrl_pkg::ST_MAX_RD;
			end
			swrl_pkg::ST_MAX_RD: begin
				state_d = max_nonempty ? swrl_pkg::ST_MAX_CMP : swrl_pkg::ST_MIN_RD;
			end
			swrl_pkg::ST_MAX_CMP: begin
				state_d = diff_ge0 ? swrl_pkg::ST_MAX_RD : swrl_pkg::ST_MIN_RD;
			end
			swrl_pkg::ST_MIN_RD: begin
				state_d = min_nonempty ? swrl_pkg::ST_MIN_CMP : swrl_pkg::ST_RNG_RD;
			end
			swrl_pkg::ST_MIN_CMP: begin
				state_d = diff_ge0 ? swrl_pkg::ST_MIN_RD : swrl_pkg::ST_RNG_RD;
			end
			swrl_pkg::ST_RNG_RD: begin
				state_d = left_lt_i ? swrl_pkg::ST_RNG_CMP : swrl_pkg::ST_DONE;
			end
			swrl_pkg::ST_RNG_CMP: begin
				state_d = shrink ? swrl_pkg::ST_RNG_RD : swrl_pkg::ST_DONE;
			end
			swrl_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) state_d = swrl_pkg::ST_IDLE;
			end
			default: state_d = swrl_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, RAM control and subtractor operands
	always_comb begin
		in_stall  = 1'b1;
		max_we    = 1'b0;
		min_we    = 1'b0;
		max_raddr = max_head_q;
		min_raddr = min_head_q;
		op_a      = max_val;
		op_b      = min_val;
		unique case (state_q)
			swrl_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			swrl_pkg::ST_MAX_RD: begin
				max_raddr = AW'(max_tail_q - CW'(1));
				max_we    = !max_nonempty;
			end
			swrl_pkg::ST_MAX_CMP: begin
				op_a   = v_q;
				op_b   = max_val;
				max_we = !diff_ge0;
			end
			swrl_pkg::ST_MIN_RD: begin
				min_raddr = AW'(min_tail_q - CW'(1));
				min_we    = !min_nonempty;
			end
			swrl_pkg::ST_MIN_CMP: begin
				op_a   = min_val;
				op_b   = v_q;
				min_we = !diff_ge0;
			end
			default: begin
			end
		endcase
	end

	// Deque RAMs
	always_ff @(posedge clk) begin
		if (max_we) max_mem[max_tail_q[AW-1:0]] <= push_entry;
		max_rdata_q <= max_mem[max_raddr];
	end

	always_ff @(posedge clk) begin
		if (min_we) min_mem[min_tail_q[AW-1:0]] <= push_entry;
		min_rdata_q <= min_mem[min_raddr];
	end

	// Hold the limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swrl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Latch the sample on acceptance
	always_ff @(posedge clk) begin
		if (in_acc) begin
			v_q   <= sample;
			ovf_q <= ovf_in;
		end
	end

	// Deque pointers, left edge, position and best length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_head_q <= '0;
			min_head_q <= '0;
			max_tail_q <= '0;
			min_tail_q <= '0;
			left_q     <= '0;
			pos_q      <= '0;
			best_q     <= '0;
		end else begin
			// clear the sequence on a start request
			if (in_acc && start_req) begin
				max_head_q <= '0;
				min_head_q <= '0;
				max_tail_q <= '0;
				min_tail_q <= '0;
				left_q     <= '0;
				pos_q      <= '0;
				best_q     <= '0;
			end
			// drop dominated tails, advance after a push
			if (max_we) max_tail_q <= max_tail_q + CW'(1);
			else if (state_q == swrl_pkg::ST_MAX_CMP && diff_ge0)
				max_tail_q <= max_tail_q - CW'(1);
			if (min_we) min_tail_q <= min_tail_q + CW'(1);
			else if (state_q == swrl_pkg::ST_MIN_CMP && diff_ge0)
				min_tail_q <= min_tail_q - CW'(1);
			// advance the left edge and pop fronts that leave the window
			if (state_q == swrl_pkg::ST_RNG_CMP && shrink) begin
				if ((CW'(max_head_q) + CW'(1) < max_tail_q) && (max_pos == left_q))
					max_head_q <= max_head_q + AW'(1);
				if ((CW'(min_head_q) + CW'(1) < min_tail_q) && (min_pos == left_q))
					min_head_q <= min_head_q + AW'(1);
				left_q <= left_q + AW'(1);
			end
			// close the sample
			if (out_load && !ovf_q) begin
				best_q <= best_c;
				pos_q  <= pos_q + CW'(1);
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			best_out_q <= best_ext[LEN_W-1:0];
			win_out_q  <= ovf_q ? '0 : win_ext[LEN_W-1:0];
			ovf_out_q  <= ovf_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign best_length   = best_out_q;
	assign window_length = win_out_q;
	assign overflow      = ovf_out_q;

	// Both deques hold at least the new sample while the window shrinks
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swrl_pkg::ST_RNG_RD || state_q == swrl_pkg::ST_RNG_CMP) |->
		(max_nonempty && min_nonempty))
		else $error("deque empty during window shrink");

	// The left edge never passes the current sample
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swrl_pkg::ST_RNG_RD || state_q == swrl_pkg::ST_RNG_CMP) |->
		(left_q <= i_idx))
		else $error("left edge beyond current sample");

	// The sample count never exceeds capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= CW'(MAX_SEQ_LEN))
		else $error("sample position beyond capacity");

	// A result is only loaded when the register is free or being drained
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && state_q == swrl_pkg::ST_DONE) |=>
		(state_q == swrl_pkg::ST_DONE))
		else $error("result lost under stall");

endmodule
